/* design/gsmt_pkg.sv */
// Package for the grouped subnet match table: field widths, beat layouts,
// item kinds, the stored rule record and the address shift helpers.
// Standalone; used by every module of the block.
package gsmt_pkg;

    localparam int ADDR_BITS  = 32;
    localparam int GROUP_W    = 32;
    localparam int PORT_W     = 16;
    localparam int SHIFT_W    = 6;
    localparam int PLEN_W     = 6;
    localparam int KIND_W     = 2;
    localparam int ENTRY_W    = 7;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 16;

    // Item kinds carried on s_axis_tuser; the fourth code is a no-op.
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_MATCH  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [GROUP_W-1:0]   group;
        logic [ADDR_BITS-1:0] subnet;
        logic [PORT_W-1:0]    port;
        logic [SHIFT_W-1:0]   shift;
    } rule_t;

    // Shift left; a shift of the full address width or more gives zero.
    function automatic logic [ADDR_BITS-1:0] shl_addr(input logic [ADDR_BITS-1:0] addr,
                                                      input logic [SHIFT_W-1:0] shift);
        logic [ADDR_BITS-1:0] res;
        if (shift >= SHIFT_W'(ADDR_BITS)) begin
            res = '0;
        end else begin
            res = addr << shift[4:0];
        end
        return res;
    endfunction

    // Prefix length to stored shift; lengths beyond the address width clamp.
    function automatic logic [SHIFT_W-1:0] prefix_to_shift(input logic [PLEN_W-1:0] plen);
        logic [SHIFT_W-1:0] res;
        if (plen > PLEN_W'(ADDR_BITS)) begin
            res = '0;
        end else begin
            res = SHIFT_W'(ADDR_BITS) - SHIFT_W'(plen);
        end
        return res;
    endfunction

endpackage

/* design/gsmt_rule_mem.sv */
// Rule store: single write port, single read port, registered read data.
// Depends on gsmt_pkg for the rule record.
module gsmt_rule_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  gsmt_pkg::rule_t   wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output gsmt_pkg::rule_t   rd_data
);

    gsmt_pkg::rule_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read word until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/grouped_subnet_match_table.sv */
// Grouped subnet match table: a sorted rule store with insert, match and
// clear items. Depends on gsmt_pkg and gsmt_rule_mem.
//
// Usage: each input beat carries one item and yields exactly one result beat.
// Rules sit in a single memory ordered by group, a new rule going after every
// rule of equal or lower group. An insert reads and moves each rule of higher
// group one place up; a match walks the rules from the bottom until it hits
// or passes the queried group. Each moved or visited rule takes a read state
// and a check state, as the store has one read port and registered read data.
// Clear, refused inserts and the unused kind go straight to the result. One
// item is worked at a time; the result sits in an output register so the
// next item is taken while the previous result waits. There is no clearing
// pass after reset: only entries below the rule count are ever read.
module grouped_subnet_match_table #(
    parameter int MAX_RULES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] group, [63:32] address, [69:64] prefix_len, [85:70] port, [87:86] zero
    input  logic [gsmt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] kind
    input  logic [gsmt_pkg::KIND_W-1:0]    s_axis_tuser,
    // Result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] hit, [1] full_res, [8:2] entry_count, [15:9] zero
    output logic [gsmt_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    // One-hot sequencer states
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_INS_RD  = 6'b000010,
        ST_INS_CHK = 6'b000100,
        ST_MAT_RD  = 6'b001000,
        ST_MAT_CHK = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    // Insert: slot being opened. Match: rule being visited.
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] pos_m1;

    logic [gsmt_pkg::GROUP_W-1:0]   group_reg, group_next;
    logic [gsmt_pkg::ADDR_BITS-1:0] addr_reg, addr_next;
    logic [gsmt_pkg::PORT_W-1:0]    port_reg, port_next;
    logic [gsmt_pkg::SHIFT_W-1:0]   shift_reg, shift_next;
    logic hit_reg, hit_next;
    logic full_reg, full_next;

    logic m_valid_reg, m_valid_next;
    logic [gsmt_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    gsmt_pkg::rule_t wr_data, rd_data, new_rule;

    logic s_acc, out_free, rule_hit;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign pos_m1 = pos_reg - 1'b1;

    assign new_rule.group  = group_reg;
    assign new_rule.subnet = gsmt_pkg::shl_addr(addr_reg, shift_reg);
    assign new_rule.port   = port_reg;
    assign new_rule.shift  = shift_reg;

    // Compare the visited rule against the query held in the item registers.
    assign rule_hit = (rd_data.subnet == gsmt_pkg::shl_addr(addr_reg, rd_data.shift)) &&
                      ((rd_data.port == port_reg) || (rd_data.port == '0));

    gsmt_rule_mem #(
        .DEPTH (MAX_RULES),
        .AW    (AW)
    ) u_rule_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        group_next   = group_reg;
        addr_next    = addr_reg;
        port_next    = port_reg;
        shift_next   = shift_reg;
        hit_next     = hit_reg;
        full_next    = full_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg[AW-1:0];
        wr_data      = new_rule;
        rd_en        = 1'b0;
        rd_addr      = pos_m1[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    group_next = s_axis_tdata[31:0];
                    addr_next  = s_axis_tdata[63:32];
                    shift_next = gsmt_pkg::prefix_to_shift(s_axis_tdata[69:64]);
                    port_next  = s_axis_tdata[85:70];
                    hit_next   = 1'b0;
                    full_next  = 1'b0;
                    case (s_axis_tuser)
                        gsmt_pkg::KIND_INSERT: begin
                            // Refuse when full, else open a slot from the top down
                            if (count_reg == CW'(MAX_RULES)) begin
                                full_next  = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                pos_next   = count_reg;
                                state_next = ST_INS_RD;
                            end
                        end
                        gsmt_pkg::KIND_MATCH: begin
                            pos_next   = '0;
                            state_next = ST_MAT_RD;
                        end
                        gsmt_pkg::KIND_CLEAR: begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INS_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK: begin
                wr_en = 1'b1;
                if (rd_data.group > group_reg) begin
                    // Move the rule below up one place and keep descending
                    wr_data    = rd_data;
                    pos_next   = pos_m1;
                    state_next = ST_INS_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_MAT_RD: begin
                rd_addr = pos_reg[AW-1:0];
                if (pos_reg == count_reg) begin
                    state_next = ST_DONE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_MAT_CHK;
                end
            end
            ST_MAT_CHK: begin
                if (rd_data.group < group_reg) begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_MAT_RD;
                end else if (rd_data.group > group_reg) begin
                    state_next = ST_DONE;
                end else if (rule_hit) begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_MAT_RD;
                end
            end
            ST_DONE: begin
                // Load the result once the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, gsmt_pkg::ENTRY_W'(count_reg), full_reg, hit_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        group_reg  <= group_next;
        addr_reg   <= addr_next;
        port_reg   <= port_next;
        shift_reg  <= shift_next;
        hit_reg    <= hit_next;
        full_reg   <= full_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* design/gsmt_checker.sv */
// Port-level checks for grouped_subnet_match_table and the bind that
// attaches them. Depends on gsmt_pkg for the item kinds.
module gsmt_checker #(
    parameter int MAX_RULES = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [gsmt_pkg::KIND_W-1:0]    s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [gsmt_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // Hold a result beat until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // One item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A result is never both a hit and a refused insert
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("hit and full_res both set");

    // Rule count never passes capacity
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (MAX_RULES > 127) || (m_axis_tdata[8:2] <= MAX_RULES))
        else $error("entry_count beyond capacity");

    // A clear on an empty output answers with an empty table by way of the done state
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_axis_tuser == gsmt_pkg::KIND_CLEAR) && !m_axis_tvalid
        |-> ##2 m_axis_tvalid && (m_axis_tdata[8:2] == 7'd0))
        else $error("clear did not empty the table");

endmodule

bind grouped_subnet_match_table gsmt_checker #(
    .MAX_RULES (MAX_RULES)
) u_gsmt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/grouped_subnet_match_table_tb.sv */
// Self-checking testbench for the grouped subnet match table: a directed table
// of items followed by randomised fill-and-query sequences, each result beat
// checked against typed values or an in-bench model of the sorted rule store. Needs gsmt_pkg.
`timescale 1ns / 100ps

module grouped_subnet_match_table_tb;

    import gsmt_pkg::*;

    localparam int     MAX_RULES    = 64;
    localparam int     CLK_HALF     = 6;
    localparam int     RESET_CYCLES = 5;
    localparam int     TARGET_ITEMS = 1700;
    // Sized to cover an insert that moves every rule.
    localparam int     DRAIN_CYCLES = 2 * MAX_RULES + 20;
    localparam longint TIMEOUT_NS   = 64'd20_000_000;
    localparam int     REPORT_LIMIT = 10;

    // The fourth kind code is not in the package enum; the block ignores it.
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    localparam bit CHECKED   = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [GROUP_W-1:0]   group;
        logic [ADDR_BITS-1:0] address;
        logic [PLEN_W-1:0]    plen;
        logic [PORT_W-1:0]    port;
    } rule_item_t;

    typedef struct {
        logic               hit;
        logic               full;
        logic [ENTRY_W-1:0] count;
    } verdict_t;

    // One row of the directed table; want is used only for CHECKED rows.
    typedef struct {
        rule_item_t item;
        bit         typed;
        verdict_t   want;
    } script_row_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [KIND_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    always #(CLK_HALF) aclk = ~aclk;

    grouped_subnet_match_table #(
        .MAX_RULES (MAX_RULES)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Model of the rule store: a sorted copy of the table held in the bench
    // ------------------------------------------------------------------
    logic [GROUP_W-1:0]   tbl_group  [MAX_RULES];
    logic [ADDR_BITS-1:0] tbl_subnet [MAX_RULES];
    logic [PORT_W-1:0]    tbl_port   [MAX_RULES];
    logic [SHIFT_W-1:0]   tbl_shift  [MAX_RULES];
    int unsigned          tbl_count = 0;

    // Results still owed by the DUT, oldest first.
    verdict_t pending_q[$];

    // Rules of the current random sequence and its group set, for queries.
    rule_item_t           episode_rules[$];
    logic [GROUP_W-1:0]   group_pool[4];
    int                   pool_size = 1;

    int unsigned n_fail = 0, n_checked = 0, sent_items = 0;
    int unsigned n_insert = 0, n_refused = 0, n_match = 0, n_hit = 0;
    int unsigned n_clear = 0, n_nop = 0;

    // Idle pattern state: calm stretches run with no gaps at all.
    bit send_calm = 1'b0;
    int send_mode_left = 0;
    bit recv_calm = 1'b0;
    int recv_mode_left = 0;
    int stall_left = 0;

    // A shift of the full address width or more clears every bit.
    function automatic logic [ADDR_BITS-1:0] addr_shifted(logic [ADDR_BITS-1:0] a,
                                                          logic [SHIFT_W-1:0] sh);
        if (sh >= ADDR_BITS) begin
            return '0;
        end
        return a << sh;
    endfunction

    // Apply one item to the model and return the result it should produce.
    function automatic verdict_t table_step(rule_item_t it);
        verdict_t           v;
        int                 pos;
        int                 k;
        int                 p;
        logic [SHIFT_W-1:0] sh;
        v.hit  = 1'b0;
        v.full = 1'b0;
        case (it.kind)
            KIND_INSERT: begin
                if (tbl_count >= MAX_RULES) begin
                    v.full = 1'b1;
                end else begin
                    // Clamp over-long prefixes to a full-width match.
                    p   = (it.plen > ADDR_BITS) ? ADDR_BITS : int'(it.plen);
                    sh  = SHIFT_W'(ADDR_BITS - p);
                    pos = tbl_count;
                    // Move higher groups up; equal groups stay below the new rule.
                    while (pos > 0 && tbl_group[pos-1] > it.group) begin
                        tbl_group[pos]  = tbl_group[pos-1];
                        tbl_subnet[pos] = tbl_subnet[pos-1];
                        tbl_port[pos]   = tbl_port[pos-1];
                        tbl_shift[pos]  = tbl_shift[pos-1];
                        pos--;
                    end
                    tbl_group[pos]  = it.group;
                    tbl_subnet[pos] = addr_shifted(it.address, sh);
                    tbl_port[pos]   = it.port;
                    tbl_shift[pos]  = sh;
                    tbl_count++;
                end
            end
            KIND_MATCH: begin
                for (k = 0; k < tbl_count; k++) begin
                    if (tbl_group[k] < it.group) continue;
                    if (tbl_group[k] > it.group) break;
                    if (tbl_subnet[k] == addr_shifted(it.address, tbl_shift[k]) &&
                        (tbl_port[k] == it.port || tbl_port[k] == '0)) begin
                        v.hit = 1'b1;
                        break;
                    end
                end
            end
            KIND_CLEAR: begin
                tbl_count = 0;
            end
            default: ;
        endcase
        v.count = ENTRY_W'(tbl_count);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Random field pickers
    // ------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small groups collide often; the extremes and wide values keep every bit busy.
    function automatic logic [GROUP_W-1:0] pick_group();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return GROUP_W'($urandom_range(0, 7));
        if (r == 5) return '0;
        if (r == 6) return '1;
        return $urandom();
    endfunction

    function automatic logic [PLEN_W-1:0] pick_plen();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return PLEN_W'(ADDR_BITS);
        if (r == 2) return PLEN_W'($urandom_range(33, 63));
        return PLEN_W'($urandom_range(1, 31));
    endfunction

    // Low address bits that survive the stored shift, i.e. the bits a rule compares.
    function automatic logic [ADDR_BITS-1:0] kept_bits(logic [PLEN_W-1:0] plen);
        int p;
        p = (plen > ADDR_BITS) ? ADDR_BITS : int'(plen);
        if (p == 0) return '0;
        return {ADDR_BITS{1'b1}} >> (ADDR_BITS - p);
    endfunction

    // Build a query: mostly aimed at a rule of this sequence, the rest noise.
    function automatic rule_item_t make_query();
        rule_item_t           q;
        rule_item_t           r;
        logic [ADDR_BITS-1:0] keep;
        q.kind = KIND_MATCH;
        q.plen = PLEN_W'($urandom_range(0, 63));
        if (episode_rules.size() > 0 && $urandom_range(0, 9) < 7) begin
            r    = episode_rules[$urandom_range(0, episode_rules.size() - 1)];
            keep = kept_bits(r.plen);
            q.group   = r.group;
            q.address = (r.address & keep) | ($urandom() & ~keep);
            // Flip a bit now and then; a flipped compared bit lands just outside the subnet.
            if ($urandom_range(0, 4) == 0) begin
                q.address ^= ADDR_BITS'(1) << $urandom_range(0, ADDR_BITS - 1);
            end
            q.port = (r.port != '0 && $urandom_range(0, 4) != 0) ?
                     r.port : PORT_W'($urandom_range(0, 65535));
        end else begin
            q.group   = $urandom_range(0, 1) ? group_pool[$urandom_range(0, pool_size - 1)]
                                             : pick_group();
            q.address = $urandom();
            q.port    = PORT_W'($urandom_range(0, 65535));
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_failure(string msg);
        n_fail++;
        if (n_fail <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_result(logic [M_TDATA_W-1:0] d);
        verdict_t want;
        if (pending_q.size() == 0) begin
            report_failure($sformatf("result beat with nothing outstanding, tdata=%h", d));
            return;
        end
        want = pending_q.pop_front();
        if (d[0] !== want.hit || d[1] !== want.full || d[8:2] !== want.count) begin
            report_failure($sformatf(
                "result %0d: expected hit=%0b full=%0b count=%0d, got hit=%0b full=%0b count=%0d",
                n_checked, want.hit, want.full, want.count, d[0], d[1], d[8:2]));
        end
        n_checked++;
    endtask

    // Result side: check each accepted beat, then choose the next tready.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                check_result(m_axis_tdata);
            end
            if (recv_mode_left == 0) begin
                recv_calm      = ($urandom_range(0, 3) == 0);
                recv_mode_left = $urandom_range(200, 2000);
            end
            recv_mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = recv_calm ? 0 : gap_length();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Present one item, hold it until accepted, then book its expected result.
    task automatic drive_item(rule_item_t it, bit typed, verdict_t want);
        verdict_t v;
        int       gap;
        if (send_mode_left == 0) begin
            send_calm      = ($urandom_range(0, 3) == 0);
            send_mode_left = $urandom_range(20, 120);
        end
        send_mode_left--;
        gap = send_calm ? 0 : gap_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.port, it.plen, it.address, it.group};
        s_axis_tuser  <= it.kind;
        do @(posedge aclk); while (!s_axis_tready);
        v = table_step(it);
        pending_q.push_back(typed ? want : v);
        case (it.kind)
            KIND_INSERT: begin
                n_insert++;
                if (v.full) n_refused++;
            end
            KIND_MATCH: begin
                n_match++;
                if (v.hit) n_hit++;
            end
            KIND_CLEAR: n_clear++;
            default:    n_nop++;
        endcase
        if (it.kind != KIND_NOP) sent_items++;
    endtask

    task automatic drive_predicted(rule_item_t it);
        verdict_t none;
        none = '{hit: 1'b0, full: 1'b0, count: '0};
        drive_item(it, PREDICTED, none);
    endtask

    function automatic script_row_t script_row(logic [KIND_W-1:0] kind,
                                               logic [GROUP_W-1:0] group,
                                               logic [ADDR_BITS-1:0] address,
                                               logic [PLEN_W-1:0] plen,
                                               logic [PORT_W-1:0] port,
                                               bit typed, logic hit, logic full,
                                               int count);
        script_row_t row;
        row.item  = '{kind: kind, group: group, address: address, plen: plen, port: port};
        row.typed = typed;
        row.want  = '{hit: hit, full: full, count: ENTRY_W'(count)};
        return row;
    endfunction

    // One random sequence: optional clear, a run of inserts over a few groups
    // with queries mixed in, then a burst of queries. Stray clears and
    // ignored-kind beats break some sequences up.
    task automatic run_episode(bit force_fill);
        int         n_rules;
        int         n_queries;
        int         k;
        rule_item_t it;
        pool_size = $urandom_range(1, 4);
        for (k = 0; k < pool_size; k++) group_pool[k] = pick_group();
        episode_rules.delete();
        if (force_fill) begin
            n_rules = MAX_RULES + 3;
        end else if ($urandom_range(0, 5) == 0) begin
            n_rules = $urandom_range(40, MAX_RULES + 6);
        end else begin
            n_rules = $urandom_range(0, 16);
        end
        n_queries = $urandom_range(2, 30);

        it = '{kind: KIND_CLEAR, group: $urandom(), address: $urandom(),
               plen: PLEN_W'($urandom_range(0, 63)), port: PORT_W'($urandom_range(0, 65535))};
        if (force_fill || $urandom_range(0, 3) != 0) drive_predicted(it);

        for (k = 0; k < n_rules; k++) begin
            it.kind    = KIND_INSERT;
            it.group   = ($urandom_range(0, 19) == 0) ? pick_group()
                                                      : group_pool[$urandom_range(0, pool_size - 1)];
            it.address = $urandom();
            it.plen    = pick_plen();
            it.port    = ($urandom_range(0, 4) == 0) ? '0 : PORT_W'($urandom_range(0, 65535));
            drive_predicted(it);
            episode_rules.push_back(it);
            if ($urandom_range(0, 7) == 0) drive_predicted(make_query());
            if ($urandom_range(0, 39) == 0) begin
                it.kind = KIND_NOP;
                drive_predicted(it);
            end
            if (!force_fill && $urandom_range(0, 79) == 0) begin
                it.kind = KIND_CLEAR;
                drive_predicted(it);
            end
        end
        for (k = 0; k < n_queries; k++) drive_predicted(make_query());
    endtask

    script_row_t script[$];

    initial begin
        // Hold reset, then release it on a clock edge.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty table, prefix extremes, port wildcard, group
        // extremes, ordering within equal groups, ignored kind and clear.
        script.push_back(script_row(KIND_MATCH,  32'd0, 32'd0, 6'd0, 16'd0,
                                    CHECKED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_NOP,    32'd0, 32'd0, 6'd0, 16'd0,
                                    CHECKED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_CLEAR,  32'd0, 32'd0, 6'd0, 16'd0,
                                    CHECKED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_INSERT, 32'd7, 32'h0A0B_0C0D, 6'd24, 16'd80,
                                    CHECKED, 1'b0, 1'b0, 1));
        script.push_back(script_row(KIND_MATCH,  32'd7, 32'hFF0B_0C0D, 6'd0, 16'd80,
                                    PREDICTED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_MATCH,  32'd7, 32'h0A0B_0C0D, 6'd0, 16'd81,
                                    PREDICTED, 1'b0, 1'b0, 0));
        // Zero prefix with port 0: matches any address and any port.
        script.push_back(script_row(KIND_INSERT, 32'd7, 32'd0, 6'd0, 16'd0,
                                    CHECKED, 1'b0, 1'b0, 2));
        script.push_back(script_row(KIND_MATCH,  32'd7, 32'hFFFF_FFFF, 6'd0, 16'hFFFF,
                                    PREDICTED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_MATCH,  32'd6, 32'h0A0B_0C0D, 6'd0, 16'd80,
                                    PREDICTED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32, 16'hFFFF,
                                    CHECKED, 1'b0, 1'b0, 3));
        // Over-long prefix is taken as a full-width one; lowest group goes first.
        script.push_back(script_row(KIND_INSERT, 32'd0, 32'h1234_5678, 6'd63, 16'd1,
                                    CHECKED, 1'b0, 1'b0, 4));
        script.push_back(script_row(KIND_INSERT, 32'd3, 32'h8000_0001, 6'd1, 16'hFFFF,
                                    CHECKED, 1'b0, 1'b0, 5));
        script.push_back(script_row(KIND_MATCH,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 16'hFFFF,
                                    PREDICTED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_MATCH,  32'hFFFF_FFFF, 32'hFFFF_FFFE, 6'd0, 16'hFFFF,
                                    PREDICTED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_MATCH,  32'd0, 32'h1234_5678, 6'd0, 16'd1,
                                    PREDICTED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_MATCH,  32'd3, 32'h0000_0001, 6'd0, 16'hFFFF,
                                    PREDICTED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_INSERT, 32'd7, 32'h0000_0005, 6'd33, 16'd2,
                                    CHECKED, 1'b0, 1'b0, 6));
        script.push_back(script_row(KIND_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 16'hFFFF,
                                    CHECKED, 1'b0, 1'b0, 6));
        script.push_back(script_row(KIND_MATCH,  32'd7, 32'h0000_0005, 6'd0, 16'd2,
                                    PREDICTED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 16'hFFFF,
                                    CHECKED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_MATCH,  32'd7, 32'h0000_0005, 6'd0, 16'd2,
                                    CHECKED, 1'b0, 1'b0, 0));
        script.push_back(script_row(KIND_INSERT, 32'hFFFF_FFFF, 32'd0, 6'd0, 16'hFFFF,
                                    CHECKED, 1'b0, 1'b0, 1));
        script.push_back(script_row(KIND_MATCH,  32'hFFFF_FFFF, 32'h5A5A_A5A5, 6'd0, 16'hFFFF,
                                    PREDICTED, 1'b0, 1'b0, 0));
        foreach (script[i]) drive_item(script[i].item, script[i].typed, script[i].want);

        // Random part: the first sequence fills the table past its capacity.
        run_episode(1'b1);
        while (sent_items < TARGET_ITEMS) run_episode(1'b0);
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays.
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d items: %0d inserts (%0d refused on a full table), %0d queries (%0d hits),",
                 sent_items + n_nop, n_insert, n_refused, n_match, n_hit);
        $display("%0d clears and %0d ignored-kind beats; %0d results checked, %0d failures.",
                 n_clear, n_nop, n_checked, n_fail);
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: stop a hung run.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", pending_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
